FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the conversion pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define F2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define F2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define F2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define F2D_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/f2d_pkg.sv
// ----------------------------------------------------------------------------
// f2d_pkg
// Types and constants of the float to scaled decimal converter.
// ----------------------------------------------------------------------------
package f2d_pkg;

    // Widest scaled mantissa: a 24-bit mantissa times ten to the 28th.
    localparam int NW            = 118;
    localparam int MIN_EXP10     = 28;
    localparam int STRIP_STEPS   = 8;
    localparam int QW            = 25;
    localparam int CW            = 96;
    localparam int MW            = 24;
    localparam int THR_KMAX      = 98;

    localparam logic [20:0] STOP_LEVEL   = 21'd1111111;
    localparam logic [31:0] RECIP10      = 32'hCCCC_CCCD;
    localparam logic [7:0]  EXP_SPECIAL  = 8'hFF;
    localparam logic [7:0]  EXP_TOO_BIG  = 8'd223;
    localparam logic [7:0]  EXP_BIAS     = 8'd150;
    localparam logic [7:0]  SUBNORM_K    = 8'd149;

    typedef struct packed {
        logic          neg;
        logic          err;
        logic          pos;
        logic          done;
        logic [4:0]    scale;
        logic [6:0]    eshift;
        logic [7:0]    k;
        logic          thr_big;
        logic [NW-1:0] thr;
        logic [NW-1:0] n;
        logic [NW-1:0] pr;
    } t_scale_item;

    typedef struct packed {
        logic          err;
        logic          neg;
        logic [4:0]    scale;
        logic [CW-1:0] coef;
    } t_result;

    function automatic logic [NW-1:0] mul10(input logic [NW-1:0] v);
        mul10 = (v << 3) + (v << 1);
    endfunction

endpackage

FILE: rtl/float32_to_scaled_decimal96.sv
// Converts an IEEE single-precision word into a sign, a 96-bit decimal
// coefficient and a power-of-ten scale, one transfer per clock cycle while
// the output is not stalled. Every item passes through one decode stage, one
// threshold stage, one stage per multiply-by-ten step of the scale search
// (28 of them), a shift stage, a rounding stage and eight zero-stripping
// stages. The pipeline advances as a whole; when the output stalls, the
// input stalls in the same cycle.
// ----------------------------------------------------------------------------
// float32_to_scaled_decimal96
// Pipelined float32 to scaled 96-bit decimal converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module float32_to_scaled_decimal96 #(
    parameter int MAX_SCALE = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_float_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_convert_error,
    output logic        o_negative,
    output logic [4:0]  o_scale,
    output logic [63:0] o_coef_low,
    output logic [31:0] o_coef_high
);
    import f2d_pkg::*;

    logic en;

    // Decode stage.
    logic          r_d_valid;
    logic          r_d_neg;
    logic          r_d_err;
    logic          r_d_pos;
    logic          r_d_zero;
    logic [MW-1:0] r_d_m;
    logic [6:0]    r_d_eshift;
    logic [7:0]    r_d_k;
    logic [7:0]    ex;

    // Threshold stage and scale chain.
    t_scale_item   w_sc  [0:MIN_EXP10];
    logic          w_scv [0:MIN_EXP10];
    t_scale_item   n_p;
    t_scale_item   r_p;
    logic          r_p_valid;

    // Shift stage.
    logic          r_r_valid;
    logic          r_r_err;
    logic          r_r_neg;
    logic          r_r_pos;
    logic          r_r_half;
    logic [4:0]    r_r_scale;
    logic [CW-1:0] r_r_q;
    logic [NW-1:0] sh_left;
    logic [NW-1:0] sh_right;
    logic [NW-1:0] sh_half;
    logic [NW-1:0] sh_tiny;
    logic [7:0]    km1;
    logic          n_half;
    logic          n_tiny;
    t_scale_item   last;

    // Rounding stage and strip chain.
    t_result       w_st  [0:STRIP_STEPS];
    logic          w_stv [0:STRIP_STEPS];
    t_result       r_a;
    logic          r_a_valid;
    t_result       n_a;
    logic [QW-1:0] rounded;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign ex = i_float_bits[30:23];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_neg    <= i_float_bits[31];
            r_d_err    <= (ex == EXP_SPECIAL) || (ex >= EXP_TOO_BIG);
            r_d_pos    <= (ex >= EXP_BIAS);
            r_d_zero   <= (i_float_bits[30:0] == 31'd0);
            r_d_m      <= {(ex != 8'd0), i_float_bits[22:0]};
            r_d_eshift <= 7'(ex - EXP_BIAS);
            r_d_k      <= (ex == 8'd0) ? SUBNORM_K : (EXP_BIAS - ex);
        end
    end

    // Stop threshold STOP_LEVEL * 2^k, flagged as out of reach when too wide.
    always_comb begin
        n_p         = '0;
        n_p.neg     = r_d_neg;
        n_p.err     = r_d_err;
        n_p.pos     = r_d_pos;
        n_p.done    = r_d_pos || r_d_zero || r_d_err;
        n_p.scale   = 5'd0;
        n_p.eshift  = r_d_eshift;
        n_p.k       = r_d_k;
        n_p.thr_big = (r_d_k >= 8'(THR_KMAX));
        n_p.thr     = NW'(STOP_LEVEL) << r_d_k[6:0];
        n_p.n       = NW'(r_d_m);
        n_p.pr      = NW'(r_d_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    assign w_sc[0]  = r_p;
    assign w_scv[0] = r_p_valid;

    for (genvar gi = 0; gi < MIN_EXP10; gi++) begin : g_scale
        f2d_scale_stage #(
            .IDX       (gi),
            .MAX_SCALE (MAX_SCALE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_scv[gi]),
            .i_item  (w_sc[gi]),
            .o_valid (w_scv[gi+1]),
            .o_item  (w_sc[gi+1])
        );
    end

    // Integer part, half bit and underflow test.
    always_comb begin
        last     = w_sc[MIN_EXP10];
        km1      = last.k - 8'd1;
        sh_left  = last.n << last.eshift;
        sh_right = last.n >> last.k;
        sh_half  = last.n >> km1;
        sh_tiny  = last.pr >> last.k;
        n_half   = !last.pos && (last.k != 8'd0) && (last.k <= 8'(NW)) && sh_half[0];
        n_tiny   = !last.done && (sh_tiny == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (en) begin
            r_r_valid <= w_scv[MIN_EXP10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_err   <= last.err || n_tiny;
            r_r_neg   <= last.neg;
            r_r_pos   <= last.pos;
            r_r_half  <= n_half;
            r_r_scale <= last.scale;
            r_r_q     <= last.pos ? sh_left[CW-1:0] : CW'(sh_right[QW-1:0]);
        end
    end

    always_comb begin
        rounded = r_r_q[QW-1:0] + QW'(r_r_half);
        n_a     = '0;
        n_a.err = r_r_err;
        if (!r_r_err) begin
            n_a.neg   = r_r_neg;
            n_a.scale = r_r_scale;
            n_a.coef  = r_r_pos ? r_r_q : CW'(rounded);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= n_a;
        end
    end

    assign w_st[0]  = r_a;
    assign w_stv[0] = r_a_valid;

    for (genvar gj = 0; gj < STRIP_STEPS; gj++) begin : g_strip
        f2d_strip_stage u_strip (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_stv[gj]),
            .i_item  (w_st[gj]),
            .o_valid (w_stv[gj+1]),
            .o_item  (w_st[gj+1])
        );
    end

    assign o_valid         = w_stv[STRIP_STEPS];
    assign o_convert_error = w_st[STRIP_STEPS].err;
    assign o_negative      = w_st[STRIP_STEPS].neg;
    assign o_scale         = w_st[STRIP_STEPS].scale;
    assign o_coef_low      = w_st[STRIP_STEPS].coef[63:0];
    assign o_coef_high     = w_st[STRIP_STEPS].coef[95:64];

    `F2D_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && o_convert_error,
        !o_negative && o_scale == 5'd0 && o_coef_low == 64'd0 && o_coef_high == 32'd0)
    `F2D_ASSERT_IMP(a_scale_max, i_clk, i_rst_n, o_valid, o_scale <= 5'(MAX_SCALE))
    `F2D_ASSERT_IMP(a_scaled_small, i_clk, i_rst_n, o_valid && o_scale != 5'd0,
        o_coef_high == 32'd0 && o_coef_low[63:25] == 39'd0)

endmodule

FILE: rtl/f2d_scale_stage.sv
// ----------------------------------------------------------------------------
// f2d_scale_stage
// One multiply-by-ten step of the scale search.
// ----------------------------------------------------------------------------
module f2d_scale_stage #(
    parameter int IDX       = 0,
    parameter int MAX_SCALE = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  f2d_pkg::t_scale_item  i_item,
    output logic                  o_valid,
    output f2d_pkg::t_scale_item  o_item
);
    import f2d_pkg::*;

    logic          r_valid;
    t_scale_item   r_item;
    t_scale_item   n_item;
    logic          ge;
    logic          step;
    logic [NW-1:0] n10;

    always_comb begin
        ge     = !i_item.thr_big && (i_item.n >= i_item.thr);
        n_item = i_item;
        if (IDX < MAX_SCALE) begin
            step = !i_item.done && !ge;
            n10  = mul10(i_item.n);
            if (step) begin
                n_item.n     = n10;
                n_item.pr    = n10;
                n_item.scale = i_item.scale + 5'd1;
            end else begin
                n_item.pr    = i_item.n;
                n_item.done  = 1'b1;
            end
        end else begin
            // Past the scale limit only the underflow probe keeps growing.
            step      = 1'b0;
            n10       = mul10(i_item.pr);
            n_item.pr = n10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/f2d_strip_stage.sv
// ----------------------------------------------------------------------------
// f2d_strip_stage
// Removes one trailing decimal zero while the scale is above zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module f2d_strip_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  f2d_pkg::t_result  i_item,
    output logic              o_valid,
    output f2d_pkg::t_result  o_item
);
    import f2d_pkg::*;

    logic          r_valid;
    t_result       r_item;
    t_result       n_item;
    logic [QW-1:0] x;
    logic [56:0]   prod;
    logic [21:0]   quo;
    logic [QW-1:0] back;
    logic          strip;

    // A nonzero scale means the coefficient fits in the low QW bits.
    always_comb begin
        x      = i_item.coef[QW-1:0];
        prod   = 57'(x) * 57'(RECIP10);
        quo    = prod[56:35];
        back   = (QW'(quo) << 3) + (QW'(quo) << 1);
        strip  = (i_item.scale != 5'd0) && (back == x);
        n_item = i_item;
        if (strip) begin
            n_item.coef  = CW'(quo);
            n_item.scale = i_item.scale - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    `F2D_ASSERT_NXT(a_strip_dec, i_clk, i_rst_n, i_en && i_valid && strip, r_item.scale + 5'd1 == $past(i_item.scale))
    `F2D_ASSERT_IMP(a_strip_err, i_clk, i_rst_n, i_valid && i_item.err, !strip)
    `F2D_ASSERT_NXT(a_strip_keep, i_clk, i_rst_n, i_en && i_valid && !strip, r_item.coef == $past(i_item.coef))

endmodule

FILE: bench/float32_to_scaled_decimal96_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float32_to_scaled_decimal96_tb
// Drives single-precision words into the converter with random gaps and
// output stalls, predicts each decimal result by exact integer scaling and
// compares every output transfer, in order, against the prediction.
// ----------------------------------------------------------------------------

typedef struct {
    logic        err;
    logic        neg;
    logic [4:0]  scale;
    logic [63:0] lo;
    logic [31:0] hi;
} t_decimal;

class decimal_scoreboard;
    t_decimal pending[$];
    int       failures;

    // Exact value of m * 10^s * 2^e as a floor and the first dropped bit.
    function automatic logic [191:0] scaled(logic [23:0] m, int e, int s, output logic half);
        logic [191:0] n;
        n = m;
        for (int i = 0; i < s; i++) n = n * 10;
        half = 1'b0;
        if (e < 0) begin
            half = n[-e - 1];
            return n >> (-e);
        end
        return n << e;
    endfunction

    function void note_float(logic [31:0] f);
        t_decimal     d;
        logic [7:0]   ex;
        logic [23:0]  m;
        logic [191:0] q;
        logic [191:0] t;
        logic         half;
        int           e;
        int           s;
        ex = f[30:23];
        d = '{1'b0, 1'b0, 5'd0, 64'd0, 32'd0};
        if (ex == 8'hFF || ex >= 8'd223) begin
            d.err = 1'b1;
            pending.push_back(d);
            return;
        end
        if (ex == 0) begin
            m = {1'b0, f[22:0]};
            e = -149;
        end else begin
            m = {1'b1, f[22:0]};
            e = int'(ex) - 150;
        end
        if (m != 0 && e < 0) begin
            t = scaled(m, e, 28, half);
            if (t == 0) begin
                d.err = 1'b1;
                pending.push_back(d);
                return;
            end
        end
        s = 0;
        forever begin
            q = scaled(m, e, s, half);
            if (q >= 1111111 || s >= 28) break;
            s++;
        end
        if (half) q = q + 1;
        while (s > 0 && q % 10 == 0) begin
            q = q / 10;
            s--;
        end
        d.neg = f[31];
        d.scale = s[4:0];
        d.lo = q[63:0];
        d.hi = q[95:64];
        pending.push_back(d);
    endfunction

    function void check_result(t_decimal got);
        t_decimal want;
        if (pending.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected result transfer");
            return;
        end
        want = pending.pop_front();
        if (got.err !== want.err || got.neg !== want.neg || got.scale !== want.scale ||
            got.lo !== want.lo || got.hi !== want.hi) begin
            failures++;
            if (failures <= 10)
                $display({"mismatch: want err=%0d neg=%0d scale=%0d coef=%h%h, ",
                          "got err=%0d neg=%0d scale=%0d coef=%h%h"},
                         want.err, want.neg, want.scale, want.hi, want.lo,
                         got.err, got.neg, got.scale, got.hi, got.lo);
        end
    endfunction
endclass

module float32_to_scaled_decimal96_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_float_bits = 32'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_convert_error;
    logic        o_negative;
    logic [4:0]  o_scale;
    logic [63:0] o_coef_low;
    logic [31:0] o_coef_high;

    decimal_scoreboard sb = new();
    int unsigned       cycles = 0;
    logic [31:0]       directed[$] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
        32'h7F80_0001, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h3F00_0000, 32'h3DCC_CCCD,
        32'h3F8C_CCCD, 32'h0000_0001, 32'h807F_FFFF, 32'h1E00_0000, 32'h1200_0000,
        32'h6F80_0000, 32'h6F7F_FFFF, 32'hEF7F_FFFF, 32'h7F7F_FFFF, 32'h4987_A238,
        32'h4B7F_FFFF, 32'hC640_E6B7, 32'h1079_0000, 32'h2F80_0001, 32'h5555_5555
    };

    float32_to_scaled_decimal96 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_float_bits(i_float_bits), .o_valid(o_valid), .i_stall(i_stall),
        .o_convert_error(o_convert_error), .o_negative(o_negative), .o_scale(o_scale),
        .o_coef_low(o_coef_low), .o_coef_high(o_coef_high)
    );

    initial forever #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Quiet stretches with no gaps alternate with stretches of random gaps.
    function automatic int draw_gap(int idx);
        if ((idx / 100) % 3 == 1) return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [31:0] random_float();
        logic [31:0] f;
        f = $urandom();
        // Most words get an exponent between 20 and 230.
        if ($urandom_range(0, 3) != 0) f[30:23] = 8'($urandom_range(20, 230));
        return f;
    endfunction

    task automatic send_float(logic [31:0] f, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_float_bits <= f;
        do @(posedge i_clk); while (o_stall);
        sb.note_float(f);
    endtask

    task automatic take_results();
        t_decimal got;
        int       idx;
        idx = 0;
        forever begin
            int gap;
            gap = draw_gap(idx + 50);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got = '{o_convert_error, o_negative, o_scale, o_coef_low, o_coef_high};
            sb.check_result(got);
            idx++;
        end
    endtask

    initial begin
        int waited;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            take_results();
        join_none
        foreach (directed[i]) send_float(directed[i], draw_gap(i));
        for (int i = 0; i < 1300; i++) begin
            if (i == 650) begin
                // Hold the input back until the pipeline has drained.
                i_valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending.size() != 0);
            end
            send_float(random_float(), draw_gap(i));
        end
        i_valid <= 1'b0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        if (sb.pending.size() != 0) sb.failures++;
        if (sb.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
